### rtl/simd_pack_unpack_unit_defines.svh
// Assertion macros for the SIMD pack/unpack unit.
// Used by modules that check their own pipeline; expect clk and rst_n in scope.
`ifndef SIMD_PACK_UNPACK_UNIT_DEFINES_SVH
`define SIMD_PACK_UNPACK_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SPU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spu: same-cycle check failed");
`define SPU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spu: next-cycle check failed");
`else
`define SPU_ASSERT_IMP(label, ante, cons)
`define SPU_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/spu_pkg.sv
// Shared types, operation codes and lane functions of the SIMD pack/unpack unit.
// No dependencies; used by every module of the unit.
`timescale 1ns / 1ps
package spu_pkg;

  localparam logic [3:0] FN_UNPCKHPD   = 4'd0;
  localparam logic [3:0] FN_PUNPCKLBW  = 4'd1;
  localparam logic [3:0] FN_PUNPCKLWD  = 4'd2;
  localparam logic [3:0] FN_PUNPCKLDQ  = 4'd3;
  localparam logic [3:0] FN_PUNPCKLQDQ = 4'd4;
  localparam logic [3:0] FN_PUNPCKHBW  = 4'd5;
  localparam logic [3:0] FN_PUNPCKHWD  = 4'd6;
  localparam logic [3:0] FN_PUNPCKHDQ  = 4'd7;
  localparam logic [3:0] FN_PUNPCKHQDQ = 4'd8;
  localparam logic [3:0] FN_PACKUSWB   = 4'd9;
  localparam logic [3:0] FN_PACKSSWB   = 4'd10;
  localparam logic [3:0] FN_PACKSSDW   = 4'd11;
  localparam logic [3:0] FN_PEXTRW     = 4'd12;

  localparam logic [7:0]  SAT_U8_MAX  = 8'hFF;
  localparam logic [7:0]  SAT_U8_MIN  = 8'h00;
  localparam logic [7:0]  SAT_S8_MAX  = 8'h7F;
  localparam logic [7:0]  SAT_S8_MIN  = 8'h80;
  localparam logic [15:0] SAT_S16_MAX = 16'h7FFF;
  localparam logic [15:0] SAT_S16_MIN = 16'h8000;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_UNPACK,
    KIND_PACKUSWB,
    KIND_PACKSSWB,
    KIND_PACKSSDW,
    KIND_EXTRACT
  } spu_kind_t;

  typedef enum logic [1:0] {
    ESZ_BYTE,
    ESZ_WORD,
    ESZ_DWORD,
    ESZ_QWORD
  } spu_esz_t;

  typedef struct packed {
    spu_kind_t    kind;
    spu_esz_t     esz;
    logic         wide;
    logic [2:0]   word_idx;
    logic [127:0] dest;
    logic [127:0] src;
    logic [63:0]  unp_a;
    logic [63:0]  unp_b;
  } spu_s1_t;

  typedef struct packed {
    spu_kind_t    kind;
    logic         wide;
    logic [127:0] unpack_res;
    logic [127:0] pack_res;
    logic [15:0]  ext_word;
  } spu_s2_t;

  function automatic logic [127:0] interleave(input logic [63:0] a, input logic [63:0] b,
                                              input spu_esz_t esz);
    logic [127:0] r;
    r = '0;
    case (esz)
      ESZ_BYTE: begin
        for (int i = 0; i < 8; i++) begin
          r[16*i +: 8]   = a[8*i +: 8];
          r[16*i+8 +: 8] = b[8*i +: 8];
        end
      end
      ESZ_WORD: begin
        for (int i = 0; i < 4; i++) begin
          r[32*i +: 16]    = a[16*i +: 16];
          r[32*i+16 +: 16] = b[16*i +: 16];
        end
      end
      ESZ_DWORD: begin
        for (int i = 0; i < 2; i++) begin
          r[64*i +: 32]    = a[32*i +: 32];
          r[64*i+32 +: 32] = b[32*i +: 32];
        end
      end
      default: r = {b, a};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sat_us8(input logic [15:0] w);
    logic [7:0] r;
    if (w[15])
      r = SAT_U8_MIN;
    else if (w[14:8] != 7'd0)
      r = SAT_U8_MAX;
    else
      r = w[7:0];
    return r;
  endfunction

  function automatic logic [7:0] sat_s8(input logic [15:0] w);
    logic [7:0] r;
    if (!w[15] && w[14:7] != 8'h00)
      r = SAT_S8_MAX;
    else if (w[15] && w[14:7] != 8'hFF)
      r = SAT_S8_MIN;
    else
      r = w[7:0];
    return r;
  endfunction

  function automatic logic [15:0] sat_s16(input logic [31:0] w);
    logic [15:0] r;
    if (!w[31] && w[30:15] != 16'h0000)
      r = SAT_S16_MAX;
    else if (w[31] && w[30:15] != 16'hFFFF)
      r = SAT_S16_MIN;
    else
      r = w[15:0];
    return r;
  endfunction

  function automatic logic [63:0] pack_uswb(input logic [127:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = sat_us8(v[16*i +: 16]);
    return r;
  endfunction

  function automatic logic [63:0] pack_sswb(input logic [127:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = sat_s8(v[16*i +: 16]);
    return r;
  endfunction

  function automatic logic [63:0] pack_ssdw(input logic [127:0] v);
    logic [63:0] r;
    for (int i = 0; i < 4; i++) r[16*i +: 16] = sat_s16(v[32*i +: 32]);
    return r;
  endfunction

endpackage

### rtl/spu_if.sv
// Valid/ready channel interfaces of the SIMD pack/unpack unit.
// Input words carry operation and operands; output words carry the 128-bit result.
`timescale 1ns / 1ps
interface spu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  func;
  logic        wide;
  logic [63:0] dest_low;
  logic [63:0] dest_high;
  logic [63:0] source_low;
  logic [63:0] source_high;
  logic [2:0]  word_index;

  modport source (output valid, func, wide, dest_low, dest_high, source_low, source_high,
                  word_index, input ready);
  modport sink (input valid, func, wide, dest_low, dest_high, source_low, source_high,
                word_index, output ready);
endinterface

interface spu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_low;
  logic [63:0] result_high;

  modport source (output valid, result_low, result_high, input ready);
  modport sink (input valid, result_low, result_high, output ready);
endinterface

### rtl/spu_decode.sv
// Stage 1: decode the operation, zero the unused operand halves, pick unpack halves.
// Depends on spu_pkg and spu_in_if.
`timescale 1ns / 1ps
module spu_decode (
  input  logic            clk,
  input  logic            rst_n,
  spu_in_if.sink          in_ch,
  output logic            s1_valid,
  input  logic            s1_ready,
  output spu_pkg::spu_s1_t s1_data
);

  logic             valid_r;
  spu_pkg::spu_s1_t data_r;
  spu_pkg::spu_s1_t data_nxt;
  logic             take;
  logic             high_sel;

  assign take        = !valid_r || s1_ready;
  assign in_ch.ready = take;
  assign s1_valid    = valid_r;
  assign s1_data     = data_r;

  always_comb begin
    data_nxt.wide     = in_ch.wide;
    data_nxt.dest     = {in_ch.wide ? in_ch.dest_high : 64'd0, in_ch.dest_low};
    data_nxt.src      = {in_ch.wide ? in_ch.source_high : 64'd0, in_ch.source_low};
    data_nxt.word_idx = in_ch.wide ? in_ch.word_index : {1'b0, in_ch.word_index[1:0]};
    data_nxt.kind     = spu_pkg::KIND_UNPACK;
    data_nxt.esz      = spu_pkg::ESZ_QWORD;
    high_sel          = 1'b0;
    unique case (in_ch.func)
      spu_pkg::FN_UNPCKHPD:   high_sel = 1'b1;
      spu_pkg::FN_PUNPCKLBW:  data_nxt.esz = spu_pkg::ESZ_BYTE;
      spu_pkg::FN_PUNPCKLWD:  data_nxt.esz = spu_pkg::ESZ_WORD;
      spu_pkg::FN_PUNPCKLDQ:  data_nxt.esz = spu_pkg::ESZ_DWORD;
      spu_pkg::FN_PUNPCKLQDQ: data_nxt.esz = spu_pkg::ESZ_QWORD;
      spu_pkg::FN_PUNPCKHBW: begin
        data_nxt.esz = spu_pkg::ESZ_BYTE;
        high_sel     = 1'b1;
      end
      spu_pkg::FN_PUNPCKHWD: begin
        data_nxt.esz = spu_pkg::ESZ_WORD;
        high_sel     = 1'b1;
      end
      spu_pkg::FN_PUNPCKHDQ: begin
        data_nxt.esz = spu_pkg::ESZ_DWORD;
        high_sel     = 1'b1;
      end
      spu_pkg::FN_PUNPCKHQDQ: high_sel = 1'b1;
      spu_pkg::FN_PACKUSWB:   data_nxt.kind = spu_pkg::KIND_PACKUSWB;
      spu_pkg::FN_PACKSSWB:   data_nxt.kind = spu_pkg::KIND_PACKSSWB;
      spu_pkg::FN_PACKSSDW:   data_nxt.kind = spu_pkg::KIND_PACKSSDW;
      spu_pkg::FN_PEXTRW:     data_nxt.kind = spu_pkg::KIND_EXTRACT;
      default:                data_nxt.kind = spu_pkg::KIND_NONE;
    endcase
    if (in_ch.wide) begin
      data_nxt.unp_a = high_sel ? data_nxt.dest[127:64] : data_nxt.dest[63:0];
      data_nxt.unp_b = high_sel ? data_nxt.src[127:64] : data_nxt.src[63:0];
    end else if (data_nxt.esz == spu_pkg::ESZ_QWORD) begin
      data_nxt.unp_a = data_nxt.dest[63:0];
      data_nxt.unp_b = data_nxt.src[63:0];
    end else if (high_sel) begin
      data_nxt.unp_a = {32'd0, data_nxt.dest[63:32]};
      data_nxt.unp_b = {32'd0, data_nxt.src[63:32]};
    end else begin
      data_nxt.unp_a = {32'd0, data_nxt.dest[31:0]};
      data_nxt.unp_b = {32'd0, data_nxt.src[31:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= in_ch.valid;
    end
    if (take && in_ch.valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/spu_exec.sv
// Stage 2: interleave, saturating packs and word extract, all in parallel.
// Depends on spu_pkg.
`timescale 1ns / 1ps
module spu_exec (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s1_valid,
  output logic             s1_ready,
  input  spu_pkg::spu_s1_t s1_data,
  output logic             s2_valid,
  input  logic             s2_ready,
  output spu_pkg::spu_s2_t s2_data
);

  logic             valid_r;
  spu_pkg::spu_s2_t data_r;
  spu_pkg::spu_s2_t data_nxt;
  logic             take;
  logic [63:0]      pk_dest;
  logic [63:0]      pk_src;

  assign take     = !valid_r || s2_ready;
  assign s1_ready = take;
  assign s2_valid = valid_r;
  assign s2_data  = data_r;

  always_comb begin
    case (s1_data.kind)
      spu_pkg::KIND_PACKUSWB: begin
        pk_dest = spu_pkg::pack_uswb(s1_data.dest);
        pk_src  = spu_pkg::pack_uswb(s1_data.src);
      end
      spu_pkg::KIND_PACKSSWB: begin
        pk_dest = spu_pkg::pack_sswb(s1_data.dest);
        pk_src  = spu_pkg::pack_sswb(s1_data.src);
      end
      default: begin
        pk_dest = spu_pkg::pack_ssdw(s1_data.dest);
        pk_src  = spu_pkg::pack_ssdw(s1_data.src);
      end
    endcase
    data_nxt.kind       = s1_data.kind;
    data_nxt.wide       = s1_data.wide;
    data_nxt.unpack_res = spu_pkg::interleave(s1_data.unp_a, s1_data.unp_b, s1_data.esz);
    data_nxt.pack_res   = s1_data.wide ? {pk_src, pk_dest}
                                       : {64'd0, pk_src[31:0], pk_dest[31:0]};
    data_nxt.ext_word   = s1_data.src[{s1_data.word_idx, 4'd0} +: 16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= s1_valid;
    end
    if (take && s1_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/spu_merge.sv
// Stage 3: select the result by operation, clear the high half when narrow, drive output.
// Depends on spu_pkg, spu_out_if and the assertion macro header.
`timescale 1ns / 1ps
`include "simd_pack_unpack_unit_defines.svh"
module spu_merge (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s2_valid,
  output logic             s2_ready,
  input  spu_pkg::spu_s2_t s2_data,
  spu_out_if.source        out_ch
);

  logic         valid_r;
  logic [127:0] res_r;
  logic [127:0] res_nxt;
  logic         take;

  assign take               = !valid_r || out_ch.ready;
  assign s2_ready           = take;
  assign out_ch.valid       = valid_r;
  assign out_ch.result_low  = res_r[63:0];
  assign out_ch.result_high = res_r[127:64];

  always_comb begin
    case (s2_data.kind) inside
      spu_pkg::KIND_UNPACK: res_nxt = s2_data.unpack_res;
      spu_pkg::KIND_PACKUSWB, spu_pkg::KIND_PACKSSWB, spu_pkg::KIND_PACKSSDW:
        res_nxt = s2_data.pack_res;
      spu_pkg::KIND_EXTRACT: res_nxt = {112'd0, s2_data.ext_word};
      default:               res_nxt = '0;
    endcase
    if (!s2_data.wide) begin
      res_nxt[127:64] = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= s2_valid;
    end
    if (take && s2_valid) begin
      res_r <= res_nxt;
    end
  end

  `SPU_ASSERT_NXT(a_narrow_high_zero, s2_valid && s2_ready && !s2_data.wide, out_ch.result_high == 64'd0)
  `SPU_ASSERT_NXT(a_extract_zero_ext, s2_valid && s2_ready && s2_data.kind == spu_pkg::KIND_EXTRACT, out_ch.result_low[63:16] == 48'd0 && out_ch.result_high == 64'd0)

endmodule

### rtl/simd_pack_unpack_unit.sv
// SIMD pack/unpack unit (MMX/SSE interleave, saturating pack, word extract).
// Top level: three-stage pipeline built from spu_decode, spu_exec and spu_merge.
//
// Usage:
//   in_ch  (spu_in_if, sink): one word per operation - func, wide, the destination
//          and source operands as low/high 64-bit halves, and word_index for pextrw.
//   out_ch (spu_out_if, source): one word per operation - result_low, result_high.
//   A word moves on a rising edge with valid and ready both high.
// Path: a word accepted on in_ch is registered in spu_decode, spu_exec, then spu_merge.
// Throughput: one word per cycle unless stalled; each stage holds one word, so three
//   words fly at once; a stage takes a new word when it is empty or its word moves on.
// Stall: when out_ch.ready is low the output holds its word; the stages behind it
//   fill and then in_ch.ready drops. Nothing is dropped or repeated.
// Reset: rst_n low at a clock edge empties all stages; in_ch.ready is high after.
// Narrow (wide = 0) operations read the operand high halves as zero and return a
//   zero result_high; unused func codes return zero.
`timescale 1ns / 1ps
`include "simd_pack_unpack_unit_defines.svh"
module simd_pack_unpack_unit (
  input  logic      clk,
  input  logic      rst_n,
  spu_in_if.sink    in_ch,
  spu_out_if.source out_ch
);

  logic             s1_valid;
  logic             s1_ready;
  spu_pkg::spu_s1_t s1_data;
  logic             s2_valid;
  logic             s2_ready;
  spu_pkg::spu_s2_t s2_data;

  spu_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_data  (s1_data)
  );

  spu_exec u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_data  (s1_data),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_data  (s2_data)
  );

  spu_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_data  (s2_data),
    .out_ch   (out_ch)
  );

  `SPU_ASSERT_IMP(a_empty_output_accepts, !out_ch.valid, in_ch.ready)
  `SPU_ASSERT_NXT(a_s1_stall_holds, s1_valid && !s1_ready, s1_valid && $stable(s1_data))

endmodule
